### hw/rtl/mftp_pkg.sv
// types and constants shared by the track event parser modules
// no dependencies
`default_nettype none

package mftp_pkg;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_MTYPE  = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHAN   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_SYSEX = 2'd1;
  localparam logic [1:0] KIND_META  = 2'd2;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_ONE_LO    = 8'hC0;
  localparam logic [7:0] ST_ONE_HI    = 8'hDF;
  localparam logic [7:0] ST_CHAN_HI   = 8'hEF;

  // up to two results caused by one track byte; the second only when has1 is set
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delta;
    logic [7:0]  meta_kind;
    logic [7:0]  byte0;
    logic        present0;
    logic        last0;
    logic        has1;
    logic [7:0]  byte1;
    logic        last1;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delta;
    logic [7:0]  meta_kind;
    logic [7:0]  msg;
    logic        present;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/mftp_front.sv
// byte parser: decodes delta times, lengths and status, builds result entries
// depends on mftp_pkg
`default_nettype none

module mftp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  output logic               push,
  output mftp_pkg::entry_t   entry
);
  import mftp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] accumulator, accumulator_next;
  logic [31:0] delta_hold, delta_hold_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [1:0]  current_kind, current_kind_next;
  logic [7:0]  meta_hold, meta_hold_next;
  logic [7:0]  status_hold, status_hold_next;
  logic [7:0]  running_status, running_status_next;
  logic        append_end, append_end_next;
  logic [31:0] acc_step;
  logic        need_one;
  logic        gen;

  assign acc_step = {accumulator[24:0], data_byte[6:0]};

  always_comb begin
    phase_next          = phase;
    accumulator_next    = accumulator;
    delta_hold_next     = delta_hold;
    bytes_left_next     = bytes_left;
    current_kind_next   = current_kind;
    meta_hold_next      = meta_hold;
    status_hold_next    = status_hold;
    running_status_next = running_status;
    append_end_next     = append_end;
    need_one            = 1'b0;
    gen                 = 1'b0;
    entry.kind      = current_kind;
    entry.delta     = delta_hold;
    entry.meta_kind = (current_kind == KIND_META) ? meta_hold : 8'h00;
    entry.byte0     = data_byte;
    entry.present0  = 1'b1;
    entry.last0     = 1'b0;
    entry.has1      = 1'b0;
    entry.byte1     = 8'h00;
    entry.last1     = 1'b0;
    case (phase)
      PH_STATUS: begin
        if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_END) begin
          current_kind_next = KIND_SYSEX;
          status_hold_next  = data_byte;
          append_end_next   = (data_byte == ST_SYSEX);
          meta_hold_next    = 8'h00;
          phase_next        = PH_LEN;
        end else if (data_byte == ST_META) begin
          current_kind_next = KIND_META;
          phase_next        = PH_MTYPE;
        end else begin
          current_kind_next = KIND_CHAN;
          meta_hold_next    = 8'h00;
          entry.kind        = KIND_CHAN;
          entry.meta_kind   = 8'h00;
          gen               = 1'b1;
          if (data_byte[7]) begin
            status_hold_next = data_byte;
            if (data_byte <= ST_CHAN_HI) begin
              running_status_next = data_byte;
            end
            need_one = (data_byte >= ST_ONE_LO && data_byte <= ST_ONE_HI) ||
                       (data_byte > ST_CHAN_HI);
            bytes_left_next = need_one ? 32'd1 : 32'd2;
            phase_next      = PH_CHAN;
          end else if (running_status[7]) begin
            // running status: status and data byte leave together
            status_hold_next = running_status;
            need_one = (running_status >= ST_ONE_LO && running_status <= ST_ONE_HI);
            entry.byte0 = running_status;
            entry.has1  = 1'b1;
            entry.byte1 = data_byte;
            entry.last1 = need_one;
            if (need_one) begin
              bytes_left_next = 32'd0;
              phase_next      = PH_DELTA;
            end else begin
              bytes_left_next = 32'd1;
              phase_next      = PH_CHAN;
            end
          end else begin
            status_hold_next = data_byte;
            bytes_left_next  = 32'd1;
            phase_next       = PH_CHAN;
          end
        end
      end
      PH_MTYPE: begin
        meta_hold_next = data_byte;
        phase_next     = PH_LEN;
      end
      PH_LEN: begin
        if (!data_byte[7]) begin
          bytes_left_next  = acc_step;
          accumulator_next = 32'd0;
          if (current_kind == KIND_SYSEX) begin
            gen         = 1'b1;
            entry.byte0 = status_hold;
            if (acc_step == 32'd0) begin
              entry.last0 = !append_end;
              entry.has1  = append_end;
              entry.byte1 = ST_SYSEX_END;
              entry.last1 = 1'b1;
              phase_next  = PH_DELTA;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            if (acc_step == 32'd0) begin
              // empty meta event marker
              gen            = 1'b1;
              entry.byte0    = 8'h00;
              entry.present0 = 1'b0;
              entry.last0    = 1'b1;
              phase_next     = PH_DELTA;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else begin
          accumulator_next = acc_step;
        end
      end
      PH_DATA: begin
        gen = 1'b1;
        if (bytes_left <= 32'd1) begin
          bytes_left_next = 32'd0;
          phase_next      = PH_DELTA;
          if (current_kind == KIND_SYSEX && append_end && data_byte != ST_SYSEX_END) begin
            entry.has1  = 1'b1;
            entry.byte1 = ST_SYSEX_END;
            entry.last1 = 1'b1;
          end else begin
            entry.last0 = 1'b1;
          end
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_CHAN: begin
        gen = 1'b1;
        if (bytes_left <= 32'd1) begin
          bytes_left_next = 32'd0;
          entry.last0     = 1'b1;
          phase_next      = PH_DELTA;
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      default: begin
        if (!data_byte[7]) begin
          delta_hold_next  = acc_step;
          accumulator_next = 32'd0;
          phase_next       = PH_STATUS;
        end else begin
          accumulator_next = acc_step;
          phase_next       = PH_DELTA;
        end
      end
    endcase
    push = accept && gen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      accumulator    <= 32'd0;
      delta_hold     <= 32'd0;
      bytes_left     <= 32'd0;
      current_kind   <= KIND_CHAN;
      meta_hold      <= 8'h00;
      status_hold    <= 8'h00;
      running_status <= 8'h00;
      append_end     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      accumulator    <= accumulator_next;
      delta_hold     <= delta_hold_next;
      bytes_left     <= bytes_left_next;
      current_kind   <= current_kind_next;
      meta_hold      <= meta_hold_next;
      status_hold    <= status_hold_next;
      running_status <= running_status_next;
      append_end     <= append_end_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mftp_fifo.sv
// short queue of result entries between the parser and the output stage
// depends on mftp_pkg
`default_nettype none

module mftp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mftp_pkg::entry_t wr_entry,
  input  wire logic             pop,
  output mftp_pkg::entry_t      rd_entry,
  output logic                  empty,
  output logic                  full
);
  import mftp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == FULL_CNT);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("entry queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("entry queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("entry queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
      push && !pop && !full |=> count == $past(count) + 1'b1)
    else $error("entry queue count lost a beat");

endmodule

`default_nettype wire

### hw/rtl/mftp_back.sv
// output stage: splits queue entries into single results, output register
// depends on mftp_pkg
`default_nettype none

module mftp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mftp_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output mftp_pkg::result_t     result
);
  import mftp_pkg::*;

  logic    second_valid;
  result_t second;
  logic    load;

  assign load = !result_valid || result_ready;
  assign pop  = load && !second_valid && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      second_valid <= 1'b0;
    end else if (load) begin
      if (second_valid) begin
        result_valid <= 1'b1;
        second_valid <= 1'b0;
      end else begin
        result_valid <= !empty;
        second_valid <= !empty && head.has1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_valid) begin
        result <= second;
      end else begin
        result.kind      <= head.kind;
        result.delta     <= head.delta;
        result.meta_kind <= head.meta_kind;
        result.msg       <= head.byte0;
        result.present   <= head.present0;
        result.last      <= head.last0;
      end
    end
    if (pop) begin
      second.kind      <= head.kind;
      second.delta     <= head.delta;
      second.meta_kind <= head.meta_kind;
      second.msg       <= head.byte1;
      second.present   <= 1'b1;
      second.last      <= head.last1;
    end
  end

  a_second_behind_first: assert property (@(posedge clk) disable iff (rst)
      second_valid |-> result_valid)
    else $error("second result pending without a first one shown");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
      pop && head.has1 |=> second_valid && result_valid && !result.last)
    else $error("pair entry not split in order");
  a_no_pop_mid_pair: assert property (@(posedge clk) disable iff (rst)
      second_valid |-> !pop)
    else $error("queue read while a second result is pending");

endmodule

`default_nettype wire

### hw/rtl/midi_file_track_event_parser_unit.sv
// track event parser top level: parser front, entry queue, output stage
// depends on mftp_pkg, mftp_front, mftp_fifo, mftp_back
//
// Takes the raw bytes of a MIDI file track one beat at a time on the data
// channel (data_valid, data_ready, data_byte) and gives one result beat per
// event message byte on the result channel (result_valid, result_ready and
// the result fields). Delta times and lengths are variable-length quantities
// wrapping at 32 bits; the last result of each event has last_of_event set.
// A byte is taken every cycle while the entry queue has room. Each byte
// gives zero, one or two results; the output stage sends one result per
// cycle while result_ready is high. An accepted byte passes through the
// entry queue and then the output register before its first result beat.
// When the receiver stalls the result stays in the output register, the
// queue fills (FIFO_DEPTH entries) and then data_ready drops.
// Reset puts the parser in the delta time phase with no running status and
// empties the queue and output register.
`default_nettype none

module midi_file_track_event_parser_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_ready,
  input  wire logic [7:0]  data_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       event_kind,
  output logic [31:0]      delta_ticks,
  output logic [7:0]       meta_kind,
  output logic [7:0]       msg_byte,
  output logic             byte_present,
  output logic             last_of_event
);
  import mftp_pkg::*;

  logic    accept;
  logic    push, pop, empty, full;
  entry_t  wr_entry, head;
  result_t result;

  assign data_ready = !full;
  assign accept     = data_valid && data_ready;

  mftp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .push      (push),
    .entry     (wr_entry)
  );

  mftp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .empty    (empty),
    .full     (full)
  );

  mftp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign event_kind    = result.kind;
  assign delta_ticks   = result.delta;
  assign meta_kind     = result.meta_kind;
  assign msg_byte      = result.msg;
  assign byte_present  = result.present;
  assign last_of_event = result.last;

endmodule

`default_nettype wire
